// ===== src/hlm_pkg.sv =====
// ----------------------------------------------------------------------------
// hlm_pkg: shared types and constants of the heartbeat liveness monitor
// Operation codes, severity codes, the command word passed from the front
// end to the back end, and reset values.
// ----------------------------------------------------------------------------
package hlm_pkg;

	localparam int NODES_DEFAULT = 16;
	localparam int OP_W = 2;
	localparam int NODE_W = 4;
	localparam int SLOT_W = 4;
	localparam int SEV_W = 2;
	localparam int CFG_W = 8;
	localparam int CNT_W = 9;
	localparam int ENTRY_W = CNT_W + SEV_W;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_W-1:0] MAX_MISSED_RESET = 8'd2;

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_BEAT = 2'd1;
	localparam logic [OP_W-1:0] OP_JOIN = 2'd2;

	typedef enum logic [SEV_W-1:0] {
		SEV_OK   = 2'd0,
		SEV_SLOW = 2'd1,
		SEV_DISC = 2'd2
	} severity_t;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_BEAT,
		CMD_JOIN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [NODE_W-1:0] node;
	} cmd_t;

endpackage

// ===== src/hlm_ifs.sv =====
// ----------------------------------------------------------------------------
// hlm interfaces: valid/ready channels of the liveness monitor
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface hlm_in_if;
	logic                      valid;
	logic                      ready;
	logic [hlm_pkg::OP_W-1:0]   operation;
	logic [hlm_pkg::NODE_W-1:0] node;

	modport source (output valid, output operation, output node, input ready);
	modport sink (input valid, input operation, input node, output ready);
endinterface

interface hlm_out_if;
	logic                      valid;
	logic                      ready;
	logic [hlm_pkg::SLOT_W-1:0] slot;
	logic [hlm_pkg::SEV_W-1:0]  severity;
	logic                      last;

	modport source (output valid, output slot, output severity, output last, input ready);
	modport sink (input valid, input slot, input severity, input last, output ready);
endinterface

interface hlm_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [hlm_pkg::CFG_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/node_heartbeat_liveness_monitor_core.sv =====
// ----------------------------------------------------------------------------
// node_heartbeat_liveness_monitor_core: heartbeat liveness monitor
// Tracks missed heartbeat ticks for a table of node slots and reports
// severity changes (ok, slow, disconnected).
// ----------------------------------------------------------------------------
// A front end takes each input transaction (tick, heartbeat, register node),
// drops unused codes and out-of-table nodes, and queues a command in a
// two-entry queue; the back end executes one command at a time against a
// single-port slot memory holding each slot's missed count and severity,
// with registered-slot flags in flip-flops cleared at reset (no clearing
// pass). A tick takes the command, visits every slot in turn, reading and
// then writing back each registered slot only, and flushes the final
// result; a heartbeat or register reads its slot and then updates it as
// needed, and a heartbeat to an unknown slot first registers it and then
// reads and updates it again. Results leave through an output register and
// are held one deep in the back end so the final one can carry last; a full
// result channel stalls the back end only, and the front keeps queuing
// meanwhile. The user must write max_missed through cfg (always ready) only
// while the block is idle; the block itself does not enforce this.
module node_heartbeat_liveness_monitor_core #(
	parameter int NODES = hlm_pkg::NODES_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	hlm_in_if.sink    items,
	hlm_out_if.source results,
	hlm_cfg_if.sink   cfg
);
	import hlm_pkg::*;

	// missed tick limit, the only configuration register
	logic [CFG_W-1:0] max_missed_q;

	// front to queue
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;

	// queue to back end
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_missed_q <= MAX_MISSED_RESET;
		end else if (cfg.valid) begin
			max_missed_q <= cfg.data;
		end
	end

	// accept and classify
	hlm_front #(
		.NODES(NODES)
	) u_front (
		.items     (items),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	// decoupling queue
	hlm_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	// sequencer, slot memory and result register
	hlm_back #(
		.NODES(NODES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_missed(max_missed_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.results   (results)
	);

endmodule

// ===== src/hlm_front.sv =====
// ----------------------------------------------------------------------------
// hlm_front: input transaction acceptance and classification
// Turns each input transaction into a command for the back end, dropping
// unused operation codes and nodes outside the table.
// ----------------------------------------------------------------------------
module hlm_front #(
	parameter int NODES = hlm_pkg::NODES_DEFAULT
) (
	hlm_in_if.sink        items,
	output logic          push_valid,
	input  logic          push_ready,
	output hlm_pkg::cmd_t push_cmd
);
	import hlm_pkg::*;

	logic      keep;
	logic      in_range;
	cmd_kind_t kind;

	assign in_range = (32'(items.node) < NODES);

	always_comb begin
		keep = 1'b0;
		kind = CMD_TICK;
		unique case (items.operation)
			OP_TICK: begin
				keep = 1'b1;
				kind = CMD_TICK;
			end
			OP_BEAT: begin
				keep = in_range;
				kind = CMD_BEAT;
			end
			OP_JOIN: begin
				keep = in_range;
				kind = CMD_JOIN;
			end
			default: begin
				keep = 1'b0;
				kind = CMD_TICK;
			end
		endcase
	end

	// dropped transactions are still taken, whenever the queue has room, so the channel never hangs
	assign items.ready   = push_ready;
	assign push_valid    = items.valid && keep;
	assign push_cmd.kind = kind;
	assign push_cmd.node = items.node;

endmodule

// ===== src/hlm_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// hlm_cmd_queue: short command queue between front and back end
// Small register FIFO that lets the front end and the back end stall
// independently.
// ----------------------------------------------------------------------------
module hlm_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  hlm_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output hlm_pkg::cmd_t pop_cmd
);
	import hlm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_QW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/hlm_back.sv =====
// ----------------------------------------------------------------------------
// hlm_back: command sequencer and slot table
// Executes tick, heartbeat and register commands against the slot memory,
// one slot read-modify-write at a time, and drives the result channel.
// ----------------------------------------------------------------------------
module hlm_back #(
	parameter int NODES = hlm_pkg::NODES_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [hlm_pkg::CFG_W-1:0]  max_missed,
	input  logic                       pop_valid,
	output logic                       pop_ready,
	input  hlm_pkg::cmd_t              pop_cmd,
	hlm_out_if.source                  results
);
	import hlm_pkg::*;

	localparam int SW = $clog2(NODES);
	localparam logic [SW-1:0] LAST_IDX = SW'(NODES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRD,
		S_TEX,
		S_NRD,
		S_NEX,
		S_FLUSH
	} state_t;

	function automatic severity_t classify(input logic [CNT_W-1:0] c,
		input logic [CNT_W-1:0] lim, input logic [CNT_W-1:0] hlf);
		severity_t s;
		if (c > lim) begin
			s = SEV_DISC;
		end else if (c > hlf) begin
			s = SEV_SLOW;
		end else begin
			s = SEV_OK;
		end
		return s;
	endfunction

	state_t              state_q;
	cmd_kind_t           kind_q;
	logic [SW-1:0]       node_q;
	logic [SW-1:0]       idx_q;
	logic [NODES-1:0]    reg_q;
	logic                pend_valid_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	severity_t           pend_sev_q;
	logic                out_valid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	severity_t           out_sev_q;
	logic                out_last_q;
	logic [ENTRY_W-1:0]  mem [NODES];
	logic [ENTRY_W-1:0]  rd_data_q;

	logic [SW-1:0]       addr;
	logic                rd_en;
	logic                we;
	logic [ENTRY_W-1:0]  wr_data;
	logic                emit;
	severity_t           emit_sev;
	logic                done_slot;
	logic [CNT_W-1:0]    limit;
	logic [CNT_W-1:0]    half;
	logic [CNT_W-1:0]    cnt;
	logic [CNT_W-1:0]    cnt_inc;
	logic [CNT_W-1:0]    cnt_dec;
	severity_t           sev_old;
	severity_t           sev_new;
	logic                snap;
	logic                out_free;
	logic                emit_ok;
	logic                flush_load;
	logic                load_out;

	assign limit    = {1'b0, max_missed};
	assign half     = {2'b00, max_missed[CFG_W-1:1]};
	assign cnt      = rd_data_q[ENTRY_W-1:SEV_W];
	assign sev_old  = severity_t'(rd_data_q[SEV_W-1:0]);
	assign sev_new  = classify(cnt, limit, half);
	assign cnt_inc  = (cnt <= limit) ? cnt + CNT_W'(1) : cnt;
	assign cnt_dec  = (cnt != '0) ? cnt - CNT_W'(1) : '0;
	assign snap     = (cnt_dec >= half);
	assign out_free = !out_valid_q || results.ready;
	assign emit_ok  = !pend_valid_q || out_free;

	assign addr  = (kind_q == CMD_TICK) ? idx_q : node_q;
	assign rd_en = (state_q == S_TRD && reg_q[idx_q]) || (state_q == S_NRD);

	assign flush_load = (state_q == S_FLUSH) && pend_valid_q && out_free;
	assign load_out   = (emit && pend_valid_q) || flush_load;
	assign pop_ready  = (state_q == S_IDLE);

	always_comb begin
		we        = 1'b0;
		wr_data   = '0;
		emit      = 1'b0;
		emit_sev  = SEV_OK;
		done_slot = 1'b0;
		case (state_q)
			S_TEX: begin
				if (sev_new != sev_old) begin
					if (emit_ok) begin
						emit      = 1'b1;
						emit_sev  = sev_new;
						we        = 1'b1;
						wr_data   = {cnt_inc, sev_new};
						done_slot = 1'b1;
					end
				end else begin
					we        = 1'b1;
					wr_data   = {cnt_inc, sev_old};
					done_slot = 1'b1;
				end
			end
			S_NEX: begin
				if (!reg_q[node_q]) begin
					if (emit_ok) begin
						emit      = 1'b1;
						we        = 1'b1;
						wr_data   = {CNT_W'(0), SEV_OK};
						done_slot = 1'b1;
					end
				end else if (kind_q == CMD_BEAT) begin
					if (snap) begin
						if (emit_ok) begin
							emit      = 1'b1;
							we        = 1'b1;
							wr_data   = {half, SEV_OK};
							done_slot = 1'b1;
						end
					end else begin
						we        = 1'b1;
						wr_data   = {cnt_dec, sev_old};
						done_slot = 1'b1;
					end
				end else begin
					done_slot = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= CMD_TICK;
			node_q       <= '0;
			idx_q        <= '0;
			reg_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			pend_sev_q   <= SEV_OK;
			out_valid_q  <= 1'b0;
			out_slot_q   <= '0;
			out_sev_q    <= SEV_OK;
			out_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						kind_q  <= pop_cmd.kind;
						node_q  <= SW'(pop_cmd.node);
						idx_q   <= '0;
						state_q <= (pop_cmd.kind == CMD_TICK) ? S_TRD : S_NRD;
					end
				end
				S_TRD: begin
					if (reg_q[idx_q]) begin
						state_q <= S_TEX;
					end else if (idx_q == LAST_IDX) begin
						state_q <= S_FLUSH;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_TEX: begin
					if (done_slot) begin
						if (idx_q == LAST_IDX) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q   <= idx_q + SW'(1);
							state_q <= S_TRD;
						end
					end
				end
				S_NRD: begin
					state_q <= S_NEX;
				end
				S_NEX: begin
					if (done_slot) begin
						if (!reg_q[node_q]) begin
							reg_q[node_q] <= 1'b1;
							state_q <= (kind_q == CMD_BEAT) ? S_NRD : S_FLUSH;
						end else begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (emit) begin
				pend_valid_q <= 1'b1;
				pend_slot_q  <= SLOT_W'(addr);
				pend_sev_q   <= emit_sev;
			end else if (flush_load) begin
				pend_valid_q <= 1'b0;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
				out_slot_q  <= pend_slot_q;
				out_sev_q   <= pend_sev_q;
				out_last_q  <= flush_load;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign results.valid    = out_valid_q;
	assign results.slot     = out_slot_q;
	assign results.severity = out_sev_q;
	assign results.last     = out_last_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending result left over when idle");

	a_write_registered: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> reg_q[$past(addr)])
		else $error("slot memory written for an unregistered slot");

	a_flush_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		flush_load |=> (out_valid_q && out_last_q && !pend_valid_q))
		else $error("final result of a command not marked last");

	a_emit_marks_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pend_valid_q) |=> (out_valid_q && !out_last_q))
		else $error("intermediate result marked last");

endmodule
